[rtl/md4bc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4bc_pkg
// Shared types, constants and step functions of the MD4 block compressor.
// ----------------------------------------------------------------------------
package md4bc_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int POS_W       = $clog2(BLOCK_WORDS);
  localparam int NUM_STEPS   = 48;
  localparam int STEP_W      = $clog2(NUM_STEPS);

  localparam logic [WORD_W-1:0] K_MAJ = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_PAR = 32'h6ED9EBA1;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

  localparam logic [1:0] RND_CHOOSE = 2'd0;
  localparam logic [1:0] RND_MAJ    = 2'd1;

  // a in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
  } md4bc_words_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FINAL
  } md4bc_state_t;

  localparam logic [POS_W-1:0] WORD_ORDER [NUM_STEPS] = '{
    4'd0, 4'd1, 4'd2,  4'd3,  4'd4, 4'd5,  4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5,  4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7,  4'd11, 4'd15,
    4'd0, 4'd8, 4'd4,  4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5,  4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  localparam logic [4:0] ROT_AMOUNT [12] = '{
    5'd3, 5'd7, 5'd11, 5'd19,
    5'd3, 5'd5, 5'd9,  5'd13,
    5'd3, 5'd9, 5'd11, 5'd15
  };

  function automatic logic [POS_W-1:0] word_index(input logic [STEP_W-1:0] step);
    logic [POS_W-1:0] idx;
    idx = '0;
    if (step < STEP_W'(NUM_STEPS)) begin
      idx = WORD_ORDER[step];
    end
    return idx;
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

[rtl/md4bc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4bc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module md4bc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/md4bc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4bc_step
// One MD4 step: round function, add, rotate and working word rotation.
// ----------------------------------------------------------------------------
module md4bc_step
  import md4bc_pkg::*;
(
  input  md4bc_words_t      work,
  input  logic [WORD_W-1:0] msg_word,
  input  logic [STEP_W-1:0] step,
  output md4bc_words_t      work_nxt
);

  logic [1:0]        rnd;
  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] sum;
  logic [4:0]        rot;

  always_comb begin
    rnd = step[STEP_W-1:STEP_W-2];
    case (rnd)
      RND_CHOOSE: f = (work.b & work.c) | (~work.b & work.d);
      RND_MAJ:    f = ((work.b & work.c) | (work.d & (work.b | work.c))) + K_MAJ;
      default:    f = (work.b ^ work.c ^ work.d) + K_PAR;
    endcase
    sum = work.a + f + msg_word;
    rot = ROT_AMOUNT[{rnd, step[1:0]}];
    // target word moves through a, d, c, b; shift the set so it is always a
    work_nxt.a = work.d;
    work_nxt.b = rotl32(sum, rot);
    work_nxt.c = work.b;
    work_nxt.d = work.c;
  end

endmodule

[rtl/md4_block_compressor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_block_compressor_top
// MD4 compression of 16-word blocks with a message word memory.
// ----------------------------------------------------------------------------
// sequence: after the 16th word of a block come a memory read setup state, the
//   48 steps and a feed-forward state that loads the digest once the output is free
// input: one word per cycle for words 0..14; no further word is taken until
//   the digest is loaded, so the 48 steps through the single step unit set the pace
// reset: synchronous active-low rst_n loads the MD4 initial value,
//   clears word position and output valid; message memory is not cleared
module md4_block_compressor_top
  import md4bc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WORD_W-1:0]   in_tdata,   // [31:0] message_word
  input  logic                in_tuser,   // [0] new_message
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [4*WORD_W-1:0] out_tdata   // [31:0] hash_a, [63:32] hash_b,
                                          // [95:64] hash_c, [127:96] hash_d
);

  md4bc_state_t      state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  md4bc_words_t      chain_r, chain_nxt;
  md4bc_words_t      work_r, work_nxt;
  md4bc_words_t      step_out;
  md4bc_words_t      out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_acc;
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  md4bc_words_t      iv;
  md4bc_words_t      feed_fwd;

  assign iv = '{d: IV_D, c: IV_C, b: IV_B, a: IV_A};

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign wr_pos     = in_tuser ? '0 : pos_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // read one step ahead to cover the memory read latency
  assign rd_addr = (state_r == ST_RUN) ? word_index(step_r + STEP_W'(1)) : word_index('0);

  assign feed_fwd.a = chain_r.a + work_r.a;
  assign feed_fwd.b = chain_r.b + work_r.b;
  assign feed_fwd.c = chain_r.c + work_r.c;
  assign feed_fwd.d = chain_r.d + work_r.d;

  md4bc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLOCK_WORDS)
  ) u_msg_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_pos),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md4bc_step u_step (
    .work     (work_r),
    .msg_word (rd_data),
    .step     (step_r),
    .work_nxt (step_out)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            chain_nxt = iv;
          end
          if (wr_pos == POS_W'(BLOCK_WORDS - 1)) begin
            pos_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            pos_nxt = wr_pos + POS_W'(1);
          end
        end
      end
      ST_LOAD: begin
        work_nxt  = chain_r;
        step_nxt  = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        work_nxt = step_out;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_STEPS - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || out_tready) begin
          chain_nxt     = feed_fwd;
          out_data_nxt  = feed_fwd;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      step_r      <= '0;
      chain_r     <= iv;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MD4 block compressor. Message words are streamed
// in with random gaps and random output back-pressure; an in-bench MD4 model
// predicts each digest, and every digest transaction is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import md4bc_pkg::*;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] MAJ_ADD = 32'h5A827999;
  localparam logic [31:0] PAR_ADD = 32'h6ED9EBA1;
  // rotate amounts, four per round, first entry in the lowest bits
  localparam logic [59:0] ROT_TAB = {5'd15, 5'd11, 5'd9, 5'd3,
                                     5'd13, 5'd9,  5'd5, 5'd3,
                                     5'd19, 5'd11, 5'd7, 5'd3};
  localparam int DRAIN_CYCLES = 64;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [WORD_W-1:0]   in_tdata = '0;   // [31:0] message_word
  logic                in_tuser = 1'b0; // [0] new_message
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [4*WORD_W-1:0] out_tdata;       // [31:0] hash_a, [63:32] hash_b,
                                        // [95:64] hash_c, [127:96] hash_d

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  // model state
  logic [31:0]  chain_words [4];
  logic [31:0]  block_words [16];
  logic [3:0]   word_slot;
  logic [127:0] digest_q [$];

  md4_block_compressor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s expected %08h got %08h", $realtime, what, want, got);
    errors++;
  endtask

  task automatic model_reset();
    chain_words[0] = INIT_A;
    chain_words[1] = INIT_B;
    chain_words[2] = INIT_C;
    chain_words[3] = INIT_D;
    word_slot = '0;
  endtask

  // takes one accepted word; after the sixteenth runs the 48 steps
  task automatic absorb_word(input logic [31:0] word, input logic flag);
    logic [31:0] ww [4];
    logic [31:0] x, y, z, f, sum;
    int t, rnd, j, idx, sh;
    if (flag) begin
      model_reset();
    end
    block_words[word_slot] = word;
    if (word_slot != 4'd15) begin
      word_slot = word_slot + 4'd1;
      return;
    end
    word_slot = '0;
    for (int k = 0; k < 4; k++) ww[k] = chain_words[k];
    for (int i = 0; i < 48; i++) begin
      t = (4 - (i % 4)) % 4;
      x = ww[(t + 1) % 4];
      y = ww[(t + 2) % 4];
      z = ww[(t + 3) % 4];
      rnd = i / 16;
      j = i % 16;
      case (rnd)
        0: begin
          f = (x & y) | (~x & z);
          idx = j;
        end
        1: begin
          f = ((x & y) | (z & (x | y))) + MAJ_ADD;
          idx = (j % 4) * 4 + j / 4;
        end
        default: begin
          f = (x ^ y ^ z) + PAR_ADD;
          // bit-reversed word order
          idx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        end
      endcase
      sh = int'(ROT_TAB[5 * (rnd * 4 + i % 4) +: 5]);
      sum = ww[t] + f + block_words[idx];
      ww[t] = (sum << sh) | (sum >> (32 - sh));
    end
    for (int k = 0; k < 4; k++) chain_words[k] = chain_words[k] + ww[k];
    digest_q.push_back({chain_words[3], chain_words[2], chain_words[1], chain_words[0]});
  endtask

  task automatic send_word(input logic [31:0] word, input logic flag);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_word(word, flag);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      2:       w = 32'h1 << $urandom_range(31);
      3:       w = ~(32'h1 << $urandom_range(31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // no flag since reset: chains from the reset value, extreme word values
  task automatic test_unflagged_start();
    logic [31:0] pattern [16];
    pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0123_4567, 32'hFEDC_BA98};
    for (int i = 0; i < 16; i++) send_word(pattern[i], 1'b0);
  endtask

  // partial block dropped by a flag; the random part finishes the new block
  task automatic test_mid_block_flag();
    for (int i = 0; i < 5; i++) send_word($urandom, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_blocks(input int n_words, input int idle, input int stall);
    logic flag;
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    for (int n = 0; n < n_words; n++) begin
      if (word_slot == 4'd0) begin
        // new message or chained block
        flag = 1'($urandom_range(1));
      end else begin
        // now and then abandon the partial block
        flag = ($urandom_range(99) == 0);
      end
      send_word(pick_word(), flag);
    end
  endtask

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest, hash_a", 32'h0, out_tdata[31:0]);
      end else begin
        want = digest_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
            report_mismatch($sformatf("hash_%c", 8'd97 + k), want[32*k +: 32],
                            out_tdata[32*k +: 32]);
          end
        end
      end
    end
  end

  initial begin
    model_reset();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unflagged_start();
    test_mid_block_flag();
    test_random_blocks(420, 0, 0);
    test_random_blocks(410, 55, 0);
    test_random_blocks(410, 0, 55);
    test_random_blocks(410, 36, 36);

    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[md4_block_compressor_top.f]
rtl/md4bc_pkg.sv
rtl/md4bc_ram.sv
rtl/md4bc_step.sv
rtl/md4_block_compressor_top.sv
bench/tb.sv
